>>> rtl/lcd_mode_timing_sequencer_macros.svh
// Assertion macros used by the LCD mode timing sequencer top level.
`ifndef LCD_MODE_TIMING_SEQUENCER_MACROS_SVH
`define LCD_MODE_TIMING_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LMTS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmts: implication check failed");

// Next-cycle implication, checked out of reset.
`define LMTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmts: next-cycle check failed");

`endif

>>> rtl/lmts_pkg.sv
// Package: types, codes and constants of the LCD mode timing sequencer.
`timescale 1ns / 1ps
package lmts_pkg;

	localparam int TICKS_W = 8;
	localparam int LINE_W  = 8;
	localparam int LEN_W   = 10;
	localparam int CFG_IDX_W = 3;

	// STAT mode codes
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_VRAM   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OAM    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VRAM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HBLANK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE   = 3'd3;

	localparam logic [LEN_W-1:0] OAM_RST    = 10'd80;
	localparam logic [LEN_W-1:0] VRAM_RST   = 10'd172;
	localparam logic [LEN_W-1:0] HBLANK_RST = 10'd204;
	localparam logic [LEN_W-1:0] LINE_RST   = 10'd456;

	localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
	localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;

	// STAT enable bit positions
	localparam int EN_HBLANK = 0;
	localparam int EN_VBLANK = 1;
	localparam int EN_OAM    = 2;
	localparam int EN_MATCH  = 3;

	typedef struct packed {
		logic [LEN_W-1:0] oam_len;
		logic [LEN_W-1:0] vram_len;
		logic [LEN_W-1:0] hblank_len;
		logic [LEN_W-1:0] line_len;
	} cfg_t;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks;
		logic               lcd_on;
		logic [LINE_W-1:0]  compare_line;
		logic [3:0]         stat_enables;
	} item_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [1:0]        mode;
		logic              line_match;
		logic              stat_irq;
		logic              vblank_irq;
		logic              frame_ready;
	} result_t;

endpackage

>>> rtl/lmts_cfg_regs.sv
// Phase length registers written through the configuration port.
`timescale 1ns / 1ps
module lmts_cfg_regs
	import lmts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [LEN_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.oam_len    <= OAM_RST;
			cfg_q.vram_len   <= VRAM_RST;
			cfg_q.hblank_len <= HBLANK_RST;
			cfg_q.line_len   <= LINE_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_OAM:    cfg_q.oam_len    <= wr_data;
				CFG_VRAM:   cfg_q.vram_len   <= wr_data;
				CFG_HBLANK: cfg_q.hblank_len <= wr_data;
				CFG_LINE:   cfg_q.line_len   <= wr_data;
				default:    ; // unknown index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/lmts_phase_core.sv
// Phase timer, mode/line sequencing and STAT status update.
`timescale 1ns / 1ps
module lmts_phase_core
	import lmts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    commit,
	output result_t res
);

	logic [LEN_W-1:0]  timer_q;
	logic [1:0]        pmode_q;
	logic [LINE_W-1:0] scan_q;
	logic [LINE_W-1:0] shown_line_q;
	logic [1:0]        shown_mode_q;
	logic              match_q;
	logic              blanked_q;

	logic [LEN_W:0]    sum;
	logic [LEN_W-1:0]  limit;
	logic              change;
	logic [LINE_W:0]   line_inc;
	logic [LEN_W-1:0]  nxt_timer;
	logic [1:0]        nxt_mode;
	logic [LINE_W-1:0] nxt_scan;
	logic [LINE_W-1:0] nxt_shown_line;
	logic [1:0]        nxt_shown_mode;
	logic              nxt_match;
	logic              nxt_blanked;
	logic              eq;
	logic              stat;
	logic              vbl;
	logic              frame;

	always_comb begin
		sum      = {1'b0, timer_q} + {{(LEN_W+1-TICKS_W){1'b0}}, item.ticks};
		line_inc = {1'b0, scan_q} + {{LINE_W{1'b0}}, 1'b1};
		case (pmode_q)
			MODE_OAM:    limit = cfg.oam_len;
			MODE_VRAM:   limit = cfg.vram_len;
			MODE_HBLANK: limit = cfg.hblank_len;
			default:     limit = cfg.line_len;
		endcase
		change = (sum >= {1'b0, limit});

		nxt_timer      = sum[LEN_W-1:0];
		nxt_mode       = pmode_q;
		nxt_scan       = scan_q;
		nxt_shown_line = shown_line_q;
		nxt_shown_mode = shown_mode_q;
		nxt_match      = match_q;
		nxt_blanked    = blanked_q;
		eq             = 1'b0;
		stat           = 1'b0;
		vbl            = 1'b0;
		frame          = 1'b0;

		if (change) begin
			nxt_timer = '0;   // excess dropped
			case (pmode_q)
				MODE_OAM:    nxt_mode = MODE_VRAM;
				MODE_VRAM:   nxt_mode = MODE_HBLANK;
				MODE_HBLANK: begin
					if (line_inc >= {1'b0, VISIBLE_LINES}) begin
						nxt_mode = MODE_VBLANK;
						vbl      = 1'b1;
						frame    = 1'b1;
					end else begin
						nxt_mode = MODE_OAM;
					end
					nxt_scan = line_inc[LINE_W-1:0];
				end
				default: begin
					if (scan_q >= LAST_LINE) begin
						nxt_mode = MODE_OAM;
						nxt_scan = '0;
					end else begin
						nxt_scan = line_inc[LINE_W-1:0];
					end
				end
			endcase

			if (!item.lcd_on) begin
				// park in vblank on the last line, LY reads 0
				if (!blanked_q)
					frame = 1'b1;
				nxt_blanked    = 1'b1;
				nxt_timer      = cfg.line_len;
				nxt_mode       = MODE_VBLANK;
				nxt_scan       = LAST_LINE;
				nxt_shown_line = '0;
				nxt_shown_mode = MODE_VBLANK;
			end else begin
				nxt_blanked    = 1'b0;
				nxt_shown_line = nxt_scan;
				nxt_shown_mode = nxt_mode;
				eq             = (nxt_scan == item.compare_line);
				nxt_match      = eq;
				stat = (nxt_mode == MODE_HBLANK && item.stat_enables[EN_HBLANK])
					|| (nxt_mode == MODE_VBLANK && item.stat_enables[EN_VBLANK])
					|| (nxt_mode == MODE_OAM && item.stat_enables[EN_OAM])
					|| (eq && item.stat_enables[EN_MATCH])
					|| (nxt_scan == VISIBLE_LINES && nxt_mode == MODE_VBLANK
						&& item.stat_enables[EN_OAM]);
			end
		end

		res.line        = nxt_shown_line;
		res.mode        = nxt_shown_mode;
		res.line_match  = nxt_match;
		res.stat_irq    = stat;
		res.vblank_irq  = vbl;
		res.frame_ready = frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q      <= '0;
			pmode_q      <= MODE_OAM;
			scan_q       <= '0;
			shown_line_q <= '0;
			shown_mode_q <= MODE_HBLANK;
			match_q      <= 1'b0;
			blanked_q    <= 1'b0;
		end else if (commit) begin
			timer_q      <= nxt_timer;
			pmode_q      <= nxt_mode;
			scan_q       <= nxt_scan;
			shown_line_q <= nxt_shown_line;
			shown_mode_q <= nxt_shown_mode;
			match_q      <= nxt_match;
			blanked_q    <= nxt_blanked;
		end
	end

endmodule

>>> rtl/lmts_out_stage.sv
// Result register with valid/ready toward the receiver.
`timescale 1ns / 1ps
module lmts_out_stage
	import lmts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (can_load)
			valid_q <= load;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

>>> rtl/lcd_mode_timing_sequencer.sv
// Top level of the LCD mode timing sequencer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready): one word per batch of dot cycles, with
//   the LCD enable, the LY compare value and the four STAT interrupt enables.
//   Output channel (out_valid/out_ready): one result word per input word:
//   shown LY and mode, coincidence flag and the STAT, VBLANK and frame pulses.
//   Config channel (cfg_valid/cfg_ready): writes the four phase lengths by
//   index; always ready, unknown indexes are dropped. Write only while idle.
//   Path: a word is accepted into the input register, processed by the phase
//   core and loaded into the result register when that register can take it.
//   Throughput: one word per cycle unless a stall holds the output; the path
//   is a single add/compare on the phase timer plus mode and line selection.
//   Reset: timer 0, mode OAM, line 0, shown status cleared, phase lengths
//   80/172/204/456. No clearing pass; words are taken right after reset.
//   Stall: when out_ready is low the result holds, the input register holds
//   its word and in_ready drops once both are full.
module lcd_mode_timing_sequencer
	import lmts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TICKS_W-1:0]   ticks,
	input  logic                 lcd_on,
	input  logic [LINE_W-1:0]    compare_line,
	input  logic [3:0]           stat_enables,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LINE_W-1:0]    line,
	output logic [1:0]           mode,
	output logic                 line_match,
	output logic                 stat_irq,
	output logic                 vblank_irq,
	output logic                 frame_ready,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data
);

`include "lcd_mode_timing_sequencer_macros.svh"

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    can_load;
	logic    advance;
	result_t res_core;
	result_t res_out;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && can_load;
	assign in_ready  = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.ticks        <= ticks;
			item_s1.lcd_on       <= lcd_on;
			item_s1.compare_line <= compare_line;
			item_s1.stat_enables <= stat_enables;
		end
	end

	lmts_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lmts_phase_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.commit (advance),
		.res    (res_core)
	);

	lmts_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_in    (res_core),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign line        = res_out.line;
	assign mode        = res_out.mode;
	assign line_match  = res_out.line_match;
	assign stat_irq    = res_out.stat_irq;
	assign vblank_irq  = res_out.vblank_irq;
	assign frame_ready = res_out.frame_ready;

	// vblank entry always reports vblank mode and a finished frame
	`LMTS_ASSERT_IMP(a_vbl_mode, out_valid && vblank_irq, mode == MODE_VBLANK && frame_ready)
	// a frame pulse without vblank entry only comes from blanking the screen
	`LMTS_ASSERT_IMP(a_blank_frame, out_valid && frame_ready && !vblank_irq,
		line == '0 && mode == MODE_VBLANK && !stat_irq)
	// a word waiting in the input register moves on once the result register frees
	`LMTS_ASSERT_NEXT(a_drain, valid_s1 && !out_valid, out_valid)

endmodule
